@@ hdl/afc_pkg.sv @@
// Types, character codes and helper functions shared by the ASCII frame checker.
`default_nettype none
package afc_pkg;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	localparam logic [31:0] TARGET_RESET = 32'h4241_5345;

	localparam logic [2:0] FIELD_SAT    = 3'd5;
	localparam logic [2:0] NAME_LEN     = 3'd4;
	localparam logic [2:0] MIN_FIELDS   = 3'd3;
	localparam logic [1:0] HEX_SAT      = 2'd3;
	localparam logic [1:0] HEX_LEN      = 2'd2;

	typedef enum logic [1:0] {
		PH_START   = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CHECK   = 2'd2,
		PH_NOSTART = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		VD_OK       = 2'd0,
		VD_FORMAT   = 2'd1,
		VD_CHECKSUM = 2'd2,
		VD_TARGET   = 2'd3
	} verdict_t;

	typedef struct packed {
		verdict_t   verdict;
		logic [7:0] payload_sum;
		logic [2:0] field_count;
	} result_t;

	// bit 4 = digit is valid, bits 3:0 = its value
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	function automatic logic [7:0] name_byte(input logic [31:0] name, input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0:    b = name[31:24];
			2'd1:    b = name[23:16];
			2'd2:    b = name[15:8];
			default: b = name[7:0];
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

@@ hdl/afc_if.sv @@
// Valid/ready channel interfaces for line bytes and verdicts.
`default_nettype none
interface afc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       line_end;

	modport source (output valid, output line_byte, output line_end, input ready);
	modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

interface afc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic [7:0] payload_sum;
	logic [2:0] field_count;

	modport source (output valid, output verdict, output payload_sum, output field_count,
		input ready);
	modport sink   (input valid, input verdict, input payload_sum, input field_count,
		output ready);
endinterface
`default_nettype wire

@@ hdl/afc_parser.sv @@
// Per-line parse state and its next-state update, with the verdict for the last byte.
`default_nettype none
module afc_parser #(
	parameter int MAX_LINE = 383
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [7:0]       line_byte,
	input  logic             line_end,
	input  logic [31:0]      target_name,
	output afc_pkg::result_t res
);
	import afc_pkg::*;

	localparam int CW = $clog2(MAX_LINE + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LINE);

	phase_t        phase_q, phase_n;
	logic          halted_q, halted_n;
	logic [7:0]    sum_q, sum_n;
	logic [3:0]    hi_q, hi_n;
	logic [1:0]    hexcnt_q, hexcnt_n;
	logic          hexok_q, hexok_n;
	logic [2:0]    fields_q, fields_n;
	logic          infield_q, infield_n;
	logic [2:0]    pos_q, pos_n;
	logic          match_q, match_n;
	logic [CW-1:0] bytes_q, bytes_n;
	logic [4:0]    hv;

	always_comb begin
		phase_n   = phase_q;
		halted_n  = halted_q;
		sum_n     = sum_q;
		hi_n      = hi_q;
		hexcnt_n  = hexcnt_q;
		hexok_n   = hexok_q;
		fields_n  = fields_q;
		infield_n = infield_q;
		pos_n     = pos_q;
		match_n   = match_q;
		bytes_n   = bytes_q;
		hv        = hex_value(line_byte);

		if (!halted_q && bytes_q < MAX_CNT) begin
			if (line_byte == CH_NUL) begin
				halted_n = 1'b1;
			end else begin
				bytes_n = bytes_q + 1'b1;
				case (phase_q)
					PH_START: begin
						phase_n = (line_byte == CH_DOLLAR) ? PH_PAYLOAD : PH_NOSTART;
					end
					PH_PAYLOAD: begin
						if (line_byte == CH_STAR) begin
							phase_n = PH_CHECK;
						end else begin
							sum_n = sum_q + line_byte;
							if (line_byte == CH_COMMA) begin
								infield_n = 1'b0;
							end else begin
								infield_n = 1'b1;
								if (!infield_q && fields_q < FIELD_SAT)
									fields_n = fields_q + 1'b1;
								if (fields_n == 3'd1) begin
									if (pos_q >= NAME_LEN) begin
										match_n = 1'b0;
									end else begin
										if (name_byte(target_name, pos_q[1:0]) != line_byte)
											match_n = 1'b0;
										pos_n = pos_q + 1'b1;
									end
								end
							end
						end
					end
					PH_CHECK: begin
						case (hexcnt_q)
							2'd0: begin
								if (hv[4])
									hi_n = hv[3:0];
								else
									hexok_n = 1'b0;
							end
							2'd1: begin
								if (!hv[4] || {hi_q, hv[3:0]} != sum_q)
									hexok_n = 1'b0;
							end
							default: hexok_n = 1'b0;
						endcase
						if (hexcnt_q < HEX_SAT)
							hexcnt_n = hexcnt_q + 1'b1;
					end
					default: ;
				endcase
			end
		end

		if (phase_n != PH_CHECK)
			res.verdict = VD_FORMAT;
		else if (!hexok_n || hexcnt_n != HEX_LEN)
			res.verdict = VD_CHECKSUM;
		else if (fields_n < MIN_FIELDS)
			res.verdict = VD_FORMAT;
		else if (!match_n || pos_n != NAME_LEN)
			res.verdict = VD_TARGET;
		else
			res.verdict = VD_OK;
		res.payload_sum = sum_n;
		res.field_count = fields_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			halted_q  <= 1'b0;
			sum_q     <= '0;
			hi_q      <= '0;
			hexcnt_q  <= '0;
			hexok_q   <= 1'b1;
			fields_q  <= '0;
			infield_q <= 1'b0;
			pos_q     <= '0;
			match_q   <= 1'b1;
			bytes_q   <= '0;
		end else if (step_en) begin
			if (line_end) begin
				phase_q   <= PH_START;
				halted_q  <= 1'b0;
				sum_q     <= '0;
				hi_q      <= '0;
				hexcnt_q  <= '0;
				hexok_q   <= 1'b1;
				fields_q  <= '0;
				infield_q <= 1'b0;
				pos_q     <= '0;
				match_q   <= 1'b1;
				bytes_q   <= '0;
			end else begin
				phase_q   <= phase_n;
				halted_q  <= halted_n;
				sum_q     <= sum_n;
				hi_q      <= hi_n;
				hexcnt_q  <= hexcnt_n;
				hexok_q   <= hexok_n;
				fields_q  <= fields_n;
				infield_q <= infield_n;
				pos_q     <= pos_n;
				match_q   <= match_n;
				bytes_q   <= bytes_n;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/ascii_frame_checker_top.sv @@
// ASCII frame checker: byte stream in, one verdict per line out.
//
// Usage: bytes of a command line arrive on the line channel, one transfer per
// byte, with line_end set on the last one. For each line one transfer on the
// result channel carries verdict (0 ok, 1 format, 2 checksum, 3 target),
// payload_sum and field_count. Bytes that are not last produce no result.
// The target name register is written through cfg_wen/cfg_wdata; the user
// must write it only while idle; the block itself does not enforce this.
// Throughput: one byte per cycle while line.ready is high. A byte is
// registered at its transfer; a single add, compare and state update then
// applies it to the line state and puts a last byte's verdict in the output
// register. When the result receiver stalls, the held verdict stays there;
// non-final bytes keep flowing, and a further last byte waits in the input
// register, which then deasserts line.ready.
// Reset clears the line state and output valid and loads the target "BASE".
`default_nettype none
module ascii_frame_checker_top #(
	parameter int MAX_LINE = 383
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [31:0]   cfg_wdata,
	afc_byte_if.sink      line,
	afc_result_if.source  result
);
	import afc_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic [31:0] target_q;
	logic        out_valid_q;
	result_t     out_q;
	result_t     res;
	logic        slot_free;
	logic        step_en;

	assign slot_free  = !out_valid_q || result.ready;
	assign step_en    = valid_s1 && (!end_s1 || slot_free);
	assign line.ready = !valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (cfg_wen) begin
			target_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line.ready) begin
			valid_s1 <= line.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line.ready && line.valid) begin
			byte_s1 <= line.line_byte;
			end_s1  <= line.line_end;
		end
	end

	afc_parser #(
		.MAX_LINE(MAX_LINE)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step_en),
		.line_byte   (byte_s1),
		.line_end    (end_s1),
		.target_name (target_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && end_s1) begin
			out_q <= res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.verdict     = out_q.verdict;
	assign result.payload_sum = out_q.payload_sum;
	assign result.field_count = out_q.field_count;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the ASCII frame checker: line bytes in, verdicts checked by a tracker.
`timescale 1ns / 1ps
module tb_top;
	import afc_pkg::*;

	localparam int LINE_MAX    = 383;
	localparam int DRAIN_TAIL  = 4;
	localparam int CYCLE_LIMIT = 400000;

	typedef logic [7:0] bytes_t[$];

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [31:0] cfg_wdata;

	afc_byte_if   line_ch ();
	afc_result_if result_ch ();

	ascii_frame_checker_top #(
		.MAX_LINE(LINE_MAX)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.line     (line_ch),
		.result   (result_ch)
	);

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int cycle_count = 0;

	result_t verdict_q[$];

	// line tracker state
	logic [31:0] target_cfg;
	phase_t      ln_phase;
	logic        ln_halted;
	logic [7:0]  ln_sum;
	logic [3:0]  ln_hi;
	logic [1:0]  ln_hex_cnt;
	logic        ln_hex_ok;
	logic [2:0]  ln_fields;
	logic        ln_in_field;
	logic [2:0]  ln_name_pos;
	logic        ln_name_ok;
	int          ln_taken;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
			return 1'b1;
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h41 + 8'd10);
			return 1'b1;
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h61 + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void clear_line_state();
		ln_phase    = PH_START;
		ln_halted   = 1'b0;
		ln_sum      = 8'd0;
		ln_hi       = 4'd0;
		ln_hex_cnt  = 2'd0;
		ln_hex_ok   = 1'b1;
		ln_fields   = 3'd0;
		ln_in_field = 1'b0;
		ln_name_pos = 3'd0;
		ln_name_ok  = 1'b1;
		ln_taken    = 0;
	endfunction

	function automatic void track_line_byte(input logic [7:0] c, input logic last);
		logic [3:0] nib;
		logic       is_hex;
		result_t    r;
		if (!ln_halted && ln_taken < LINE_MAX) begin
			if (c == CH_NUL) begin
				ln_halted = 1'b1;
			end else begin
				ln_taken++;
				case (ln_phase)
					PH_START: begin
						ln_phase = (c == CH_DOLLAR) ? PH_PAYLOAD : PH_NOSTART;
					end
					PH_PAYLOAD: begin
						if (c == CH_STAR) begin
							ln_phase = PH_CHECK;
						end else begin
							ln_sum = ln_sum + c;
							if (c == CH_COMMA) begin
								ln_in_field = 1'b0;
							end else begin
								if (!ln_in_field) begin
									ln_in_field = 1'b1;
									if (ln_fields < FIELD_SAT)
										ln_fields++;
								end
								if (ln_fields == 3'd1) begin
									if (ln_name_pos >= NAME_LEN) begin
										ln_name_ok = 1'b0;
									end else begin
										if (target_cfg[8 * (3 - int'(ln_name_pos)) +: 8] != c)
											ln_name_ok = 1'b0;
										ln_name_pos++;
									end
								end
							end
						end
					end
					PH_CHECK: begin
						is_hex = hex_digit(c, nib);
						if (ln_hex_cnt == 2'd0) begin
							if (is_hex)
								ln_hi = nib;
							else
								ln_hex_ok = 1'b0;
						end else if (ln_hex_cnt == 2'd1) begin
							if (!is_hex || {ln_hi, nib} != ln_sum)
								ln_hex_ok = 1'b0;
						end else begin
							ln_hex_ok = 1'b0;
						end
						if (ln_hex_cnt < HEX_SAT)
							ln_hex_cnt++;
					end
					default: ;
				endcase
			end
		end
		if (last) begin
			if (ln_phase != PH_CHECK)
				r.verdict = VD_FORMAT;
			else if (!ln_hex_ok || ln_hex_cnt != HEX_LEN)
				r.verdict = VD_CHECKSUM;
			else if (ln_fields < MIN_FIELDS)
				r.verdict = VD_FORMAT;
			else if (!ln_name_ok || ln_name_pos != NAME_LEN)
				r.verdict = VD_TARGET;
			else
				r.verdict = VD_OK;
			r.payload_sum = ln_sum;
			r.field_count = ln_fields;
			verdict_q.push_back(r);
			clear_line_state();
		end
	endfunction

	// stimulus helpers
	function automatic bytes_t str_bytes(input string s);
		bytes_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + 8'(n);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] field_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 3) == 0)
				c = 8'($urandom_range(1, 255));
			else
				c = 8'($urandom_range(8'h21, 8'h7E));
		end while (c == CH_COMMA || c == CH_STAR);
		return c;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		logic [3:0] nib;
		do c = 8'($urandom_range(1, 255)); while (hex_digit(c, nib));
		return c;
	endfunction

	// '$' payload '*' and two hex digits of the sum offset by delta
	function automatic bytes_t frame(input bytes_t payload, input logic [7:0] delta);
		bytes_t     q;
		logic [7:0] s;
		s = delta;
		foreach (payload[i])
			s = s + payload[i];
		q = payload;
		q.push_front(CH_DOLLAR);
		q.push_back(CH_STAR);
		q.push_back(hex_char(s[7:4]));
		q.push_back(hex_char(s[3:0]));
		return q;
	endfunction

	function automatic bytes_t rand_payload(input int nfields, input logic name_ok);
		bytes_t p;
		int     len;
		if ($urandom_range(0, 3) == 0)
			p.push_back(CH_COMMA);
		for (int f = 0; f < nfields; f++) begin
			if (f > 0) begin
				p.push_back(CH_COMMA);
				if ($urandom_range(0, 5) == 0)
					p.push_back(CH_COMMA);
			end
			if (f == 0 && name_ok) begin
				for (int k = 3; k >= 0; k--)
					p.push_back(target_cfg[8 * k +: 8]);
			end else begin
				len = $urandom_range(1, 6);
				repeat (len) p.push_back(field_char());
			end
		end
		if ($urandom_range(0, 5) == 0)
			p.push_back(CH_COMMA);
		return p;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			line_ch.valid <= 1'b0;
			@(posedge clk);
		end
		line_ch.valid     <= 1'b1;
		line_ch.line_byte <= b;
		line_ch.line_end  <= last;
		do @(posedge clk); while (!line_ch.ready);
		track_line_byte(b, last);
	endtask

	task automatic send_line(input bytes_t ln);
		foreach (ln[i])
			send_byte(ln[i], i == ln.size() - 1);
	endtask

	task automatic drain();
		line_ch.valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic set_target(input logic [31:0] v);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen    <= 1'b0;
		target_cfg  = v;
	endtask

	// directed tests
	task automatic test_good_frames();
		bytes_t pl;
		send_line(frame(str_bytes("BASE,a,b"), 8'd0));
		send_line(frame(str_bytes(",BASE,,x,y,z,w,"), 8'd0));
		pl = str_bytes("BASE,");
		pl.push_back(8'h7F);
		pl.push_back(8'h80);
		pl.push_back(CH_COMMA);
		pl.push_back(8'hFF);
		send_line(frame(pl, 8'd0));
	endtask

	task automatic test_format_errors();
		bytes_t ln;
		send_byte(CH_NUL, 1'b1);
		send_line(str_bytes("$"));
		send_line(str_bytes("BASE,a,b*00"));
		send_line(str_bytes("$BASE,a,b"));
		send_line(frame(str_bytes("BASE,a"), 8'd0));
		ln = frame(str_bytes("BASE,,"), 8'd0);
		send_line(ln);
	endtask

	task automatic test_checksum_errors();
		bytes_t ln;
		send_line(frame(str_bytes("BASE,a,b"), 8'd1));
		send_line(str_bytes("$BASE,a,b**0"));
		ln = frame(str_bytes("BASE,a,b"), 8'd0);
		void'(ln.pop_back());
		send_line(ln);
		ln = frame(str_bytes("BASE,a,b"), 8'd0);
		ln.push_back(8'h30);
		send_line(ln);
		ln = frame(str_bytes("BASE,a,b"), 8'd0);
		ln[ln.size() - 2] = 8'h47;
		send_line(ln);
	endtask

	task automatic test_long_line();
		bytes_t pl;
		bytes_t ln;
		pl = str_bytes("BASE,a,b");
		while (pl.size() < LINE_MAX - 4)
			pl.push_back(8'h63);
		ln = frame(pl, 8'd0);
		ln.push_back(8'h2A);
		ln.push_back(8'h41);
		send_line(ln);
		pl.push_back(8'h63);
		send_line(frame(pl, 8'd0));
	endtask

	task automatic test_zero_byte();
		bytes_t ln;
		ln = frame(str_bytes("BASE,x,y"), 8'd0);
		ln.push_back(CH_NUL);
		ln.push_back(8'h5A);
		send_line(ln);
		ln = frame(str_bytes("BASE,x,y"), 8'd0);
		ln.insert(3, CH_NUL);
		send_line(ln);
	endtask

	task automatic test_target();
		send_line(frame(str_bytes("BASEX,a,b"), 8'd0));
		send_line(frame(str_bytes("BAS,a,b"), 8'd0));
		send_line(frame(str_bytes("base,a,b"), 8'd0));
		set_target(32'h4241_0045);
		send_line(frame(str_bytes("BAE,a,b"), 8'd0));
		set_target(32'h0000_0000);
		send_line(frame(str_bytes("BASE,a,b"), 8'd0));
	endtask

	task automatic test_random(input int n_bytes);
		bytes_t ln;
		bytes_t pl;
		int     sent;
		int     kind;
		sent = 0;
		while (sent < n_bytes) begin
			kind = $urandom_range(0, 99);
			pl = rand_payload($urandom_range(1, 6), $urandom_range(0, 9) != 0);
			ln = frame(pl, 8'd0);
			if (kind < 60) begin
			end else if (kind < 68) begin
				ln = frame(pl, 8'($urandom_range(1, 255)));
			end else if (kind < 72) begin
				void'(ln.pop_back());
			end else if (kind < 76) begin
				ln.push_back($urandom_range(0, 1) ? hex_char(4'($urandom())) : CH_STAR);
			end else if (kind < 80) begin
				ln[ln.size() - 1 - $urandom_range(0, 1)] = non_hex_char();
			end else if (kind < 84) begin
				ln[0] = field_char();
			end else if (kind < 88) begin
				ln = pl;
				ln.push_front(CH_DOLLAR);
			end else if (kind < 90) begin
				void'(ln.pop_back());
				void'(ln.pop_back());
			end else if (kind < 98) begin
				ln.delete();
				repeat ($urandom_range(1, 24)) ln.push_back(8'($urandom_range(0, 255)));
			end else begin
				while (pl.size() < $urandom_range(370, 385))
					pl.push_back(field_char());
				ln = frame(pl, 8'd0);
				repeat ($urandom_range(0, 20)) ln.push_back(field_char());
			end
			if ($urandom_range(0, 9) == 0) begin
				ln.insert($urandom_range(0, ln.size()), CH_NUL);
				repeat ($urandom_range(0, 3)) ln.push_back(8'($urandom_range(0, 255)));
			end
			send_line(ln);
			sent += ln.size();
		end
	endtask

	// verdict checker and receiver stalls
	always @(posedge clk) begin : check_verdicts
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected verdict transfer: verdict %0d sum %0d fields %0d",
					$time, result_ch.verdict, result_ch.payload_sum, result_ch.field_count);
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (result_ch.verdict !== want.verdict) begin
					$display("%0t: verdict expected %0d actual %0d",
						$time, want.verdict, result_ch.verdict);
					errors++;
				end
				if (result_ch.payload_sum !== want.payload_sum) begin
					$display("%0t: payload_sum expected %0d actual %0d",
						$time, want.payload_sum, result_ch.payload_sum);
					errors++;
				end
				if (result_ch.field_count !== want.field_count) begin
					$display("%0t: field_count expected %0d actual %0d",
						$time, want.field_count, result_ch.field_count);
					errors++;
				end
			end
		end
		result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ascii_frame_checker_top: mismatch");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		cfg_wen           = 1'b0;
		cfg_wdata         = 32'd0;
		line_ch.valid     = 1'b0;
		line_ch.line_byte = 8'd0;
		line_ch.line_end  = 1'b0;
		result_ch.ready   = 1'b0;
		target_cfg        = TARGET_RESET;
		clear_line_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 34;
		recv_idle_pct = 74;
		test_good_frames();
		test_format_errors();
		test_checksum_errors();
		test_long_line();
		test_zero_byte();
		test_target();

		set_target(32'hFFFF_FFFF);
		test_random(220);

		set_target({field_char(), field_char(), field_char(), field_char()});
		send_idle_pct = 74;
		recv_idle_pct = 34;
		test_random(220);

		set_target(TARGET_RESET);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(220);

		drain();
		if (errors == 0)
			$display("ascii_frame_checker_top: match");
		else
			$display("ascii_frame_checker_top: mismatch");
		$finish;
	end

endmodule
